### rtl/core/cse_pkg.sv
package cse_pkg;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_U         = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CTRL_MAX     = 8'h1F;

    localparam int QUEUE_DEPTH = 2;

    // Position within the run of bytes emitted for one input byte.
    localparam int POS_W = 3;
    localparam logic [POS_W-1:0] POS_FIRST    = 3'd0;
    localparam logic [POS_W-1:0] POS_SHORT_LAST = 3'd1;
    localparam logic [POS_W-1:0] POS_U        = 3'd1;
    localparam logic [POS_W-1:0] POS_ZERO_HI  = 3'd2;
    localparam logic [POS_W-1:0] POS_ZERO_LO  = 3'd3;
    localparam logic [POS_W-1:0] POS_HEX_HI   = 3'd4;
    localparam logic [POS_W-1:0] POS_UNI_LAST = 3'd5;

    typedef enum logic [1:0] {
        KIND_PASS  = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_UNI   = 2'd2
    } kind_t;

    // One classified input byte: how to expand it and the byte it carries.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value;
    } item_t;

    function automatic item_t classify(input logic [7:0] b);
        item_t it;
        it.kind  = KIND_PASS;
        it.value = b;
        unique case (b)
            CH_QUOTE, CH_BACKSLASH: it.kind = KIND_SHORT;
            8'h08: begin it.kind = KIND_SHORT; it.value = 8'h62; end
            8'h0C: begin it.kind = KIND_SHORT; it.value = 8'h66; end
            8'h0A: begin it.kind = KIND_SHORT; it.value = 8'h6E; end
            8'h0D: begin it.kind = KIND_SHORT; it.value = 8'h72; end
            8'h09: begin it.kind = KIND_SHORT; it.value = 8'h74; end
            8'h0B: begin it.kind = KIND_SHORT; it.value = 8'h76; end
            default:
            begin
                if (b <= CTRL_MAX)
                begin
                    it.kind = KIND_UNI;
                end
            end
        endcase
        return it;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] d;
        if (nib < 4'd10)
        begin
            d = CH_ZERO + {4'd0, nib};
        end
        else
        begin
            d = CH_LOWER_A + {4'd0, nib} - 8'd10;
        end
        return d;
    endfunction

    function automatic logic [7:0] expand_byte(input item_t it, input logic [POS_W-1:0] pos);
        logic [7:0] o;
        o = it.value;
        unique case (it.kind)
            KIND_PASS:  o = it.value;
            KIND_SHORT: o = (pos == POS_FIRST) ? CH_BACKSLASH : it.value;
            KIND_UNI:
            begin
                unique case (pos)
                    POS_FIRST:   o = CH_BACKSLASH;
                    POS_U:       o = CH_U;
                    POS_ZERO_HI: o = CH_ZERO;
                    POS_ZERO_LO: o = CH_ZERO;
                    POS_HEX_HI:  o = hex_digit(it.value[7:4]);
                    default:     o = hex_digit(it.value[3:0]);
                endcase
            end
            default:    o = it.value;
        endcase
        return o;
    endfunction

    function automatic logic is_last(input item_t it, input logic [POS_W-1:0] pos);
        logic l;
        unique case (it.kind)
            KIND_PASS:  l = 1'b1;
            KIND_SHORT: l = (pos == POS_SHORT_LAST);
            KIND_UNI:   l = (pos == POS_UNI_LAST);
            default:    l = 1'b1;
        endcase
        return l;
    endfunction

endpackage

### rtl/core/cse_front.sv
module cse_front
    import cse_pkg::*;
(
    input  logic [7:0] in_byte,
    output item_t      item
);

    // Each raw byte is sorted into pass-through, two-byte or six-byte escape.
    assign item = classify(in_byte);

endmodule

### rtl/core/cse_queue.sv
module cse_queue
    import cse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  item_t                      wr_item,
    input  logic                       rd_en,
    output item_t                      rd_item,
    output logic                       not_empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        if (p == PTR_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = p + 1'b1;
        end
        return n;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item   = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign count     = count_reg;

endmodule

### rtl/core/cse_back.sv
module cse_back
    import cse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  item_t      head_item,
    output logic       head_done,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic             out_last_reg,  out_last_next;
    logic [POS_W-1:0] pos_reg,       pos_next;
    logic             load;
    logic             last_now;

    // The output register takes a new byte whenever an item is waiting and the register is free or being drained.
    assign load     = head_valid && (!out_valid_reg || pop);
    assign last_now = is_last(head_item, pos_reg);
    assign head_done = load && last_now;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pos_next       = pos_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = expand_byte(head_item, pos_reg);
            out_last_next  = last_now;
            pos_next       = last_now ? POS_FIRST : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_FIRST;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

endmodule

### rtl/core/c_string_escape_encoder_top.sv
// String escape encoder. Every byte pushed in comes out as one to six
// bytes, the final byte of each run flagged by out_last: a double quote or
// backslash becomes a backslash and that character; backspace, form feed,
// newline, carriage return, tab and vertical tab become a backslash and b,
// f, n, r, t or v; any other byte from 0x00 to 0x1F becomes backslash, u,
// 0, 0 and two lowercase hex digits; every other byte passes unchanged.
// Both sides behave as a queue. An input byte is taken on a transfer with
// push high and full low; an output byte leaves on a transfer with pop high
// and empty low. The output side delivers one byte per clock while pop
// stays high and items are waiting, so an escape occupies the single
// output register for two or six bytes; the input can take one byte per
// cycle as long as the small item queue between the classifier and the
// expander has room. A byte pushed into an idle block is first written
// into the item queue and then loaded into the output register, and its
// first output transfer can happen once it is on the output ports.
module c_string_escape_encoder_top
    import cse_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH_P + 1);

    item_t            front_item;
    item_t            head_item;
    logic             head_valid;
    logic             head_done;
    logic             push_ok;
    logic [CNT_W-1:0] q_count;

    assign push_ok = push && !full;

    // The front end classifies the byte in the cycle it is transferred in.
    cse_front u_front
    (
        .in_byte (in_byte),
        .item    (front_item)
    );

    // Classified items wait here so that each side can stall on its own.
    cse_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (push_ok),
        .wr_item   (front_item),
        .rd_en     (head_done),
        .rd_item   (head_item),
        .not_empty (head_valid),
        .full      (full),
        .count     (q_count)
    );

    // The back end walks each item through its run of output bytes.
    cse_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_done  (head_done),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .out_last   (out_last)
    );

    // The queue never holds more items than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH_P))
    else $error("item queue count exceeds its depth");

    // An accepted byte is always waiting in the queue on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        push_ok |=> (q_count != '0))
    else $error("accepted byte missing from the item queue");

    // Only escape bytes can appear before the end of a run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !out_last) |-> (out_byte == CH_BACKSLASH || out_byte == CH_U ||
                                   out_byte == CH_ZERO || out_byte == 8'h31))
    else $error("unexpected byte inside an escape run");

endmodule

### tb/tb_c_string_escape_encoder_top.sv
module tb_c_string_escape_encoder_top;
    import cse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The run is cut off at this many clock cycles. The slowest legal run is
    // at most 495 bytes, each expanding to up to six output bytes that may
    // each wait out the longest stall that pick_gap draws on the pop side.
    localparam int CYCLE_LIMIT = 600000;

    // Cycles to keep watching after the last expected byte has left, so that
    // any spurious extra output byte is caught.
    localparam int SETTLE_CYCLES = 12;

    // Lowercase hex digits used to predict the tail of a \u00XX escape.
    localparam string HEX_CHARS = "0123456789abcdef";

    // One predicted output byte together with its end-of-run flag.
    typedef struct {
        logic [7:0] data;
        logic       last;
    } esc_byte_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_last;

    // Escaped bytes still owed by the block, oldest first.
    esc_byte_t escaped_q[$];

    int errors;
    int cycles;
    int n_inputs;
    int n_outputs;
    int n_plain;
    int n_short;
    int n_unicode;

    // When set, the output side pops on every cycle; otherwise it stalls at
    // random.
    bit pop_always;

    c_string_escape_encoder_top u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("%0t: timeout after %0d cycles, %0d bytes still expected",
                         $time, cycles, escaped_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random source byte. Control bytes and the two quoted characters are
    // weighted up so that every kind of escape shows up often; the rest
    // spans the whole byte range.
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            return 8'($urandom_range(0, 31));
        end
        else if (r < 45)
        begin
            return ($urandom_range(0, 1) != 0) ? CH_QUOTE : CH_BACKSLASH;
        end
        else if (r < 50)
        begin
            return 8'h7F;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void owe_byte(input logic [7:0] data, input logic last);
        esc_byte_t e;
        e.data = data;
        e.last = last;
        escaped_q.insert(escaped_q.size(), e);
    endfunction

    // Predicts the run of output bytes that one accepted source byte causes
    // and appends it to the queue of owed bytes.
    function automatic void predict_escape(input logic [7:0] b);
        logic [7:0] letter;
        letter = 8'h00;
        case (b)
            8'h22:   letter = 8'h22;
            8'h5C:   letter = 8'h5C;
            8'h08:   letter = "b";
            8'h0C:   letter = "f";
            8'h0A:   letter = "n";
            8'h0D:   letter = "r";
            8'h09:   letter = "t";
            8'h0B:   letter = "v";
            default: letter = 8'h00;
        endcase

        if (letter != 8'h00)
        begin
            // Two-byte escape: backslash and the letter or the character.
            owe_byte(8'h5C, 1'b0);
            owe_byte(letter, 1'b1);
            n_short++;
        end
        else if (b < 8'h20)
        begin
            // Remaining control bytes, zero among them, become \u00XX.
            owe_byte(8'h5C, 1'b0);
            owe_byte("u", 1'b0);
            owe_byte("0", 1'b0);
            owe_byte("0", 1'b0);
            owe_byte(HEX_CHARS[b[7:4]], 1'b0);
            owe_byte(HEX_CHARS[b[3:0]], 1'b1);
            n_unicode++;
        end
        else
        begin
            // Printable, delete and high bytes pass through as they are.
            owe_byte(b, 1'b1);
            n_plain++;
        end
    endfunction

    // Offers one source byte and holds it until the block takes it. Push is
    // left high on return so that a following byte can go out back to back;
    // hold_input lowers it when the sender is to pause.
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        push    <= 1'b1;
        in_byte <= b;
        do
        begin
            @(posedge clk);
        end
        while (full);
        predict_escape(b);
        n_inputs++;
    endtask

    task automatic hold_input(input int n);
        repeat (n)
        begin
            @(negedge clk);
            push    <= 1'b0;
            in_byte <= 8'($urandom_range(0, 255));
        end
    endtask

    // Waits until every owed byte has been popped. Push must be low.
    task automatic wait_drained();
        while (escaped_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Sends n random bytes, with random gaps on the input side if asked.
    task automatic send_random(input int n, input bit with_gaps);
        int gap;
        for (int i = 0; i < n; i++)
        begin
            gap = with_gaps ? pick_gap() : 0;
            if (gap > 0)
            begin
                hold_input(gap);
            end
            send_byte(pick_byte());
        end
    endtask

    // Output side: pops on every cycle or in bursts broken by random stalls.
    // Each falling edge carries exactly one assignment to pop.
    initial
    begin
        int on_len;
        int off_len;
        forever
        begin
            if (pop_always)
            begin
                @(negedge clk);
                pop <= 1'b1;
            end
            else
            begin
                on_len  = $urandom_range(1, 8);
                off_len = pick_gap();
                repeat (on_len)
                begin
                    @(negedge clk);
                    pop <= 1'b1;
                end
                repeat (off_len)
                begin
                    @(negedge clk);
                    pop <= 1'b0;
                end
            end
        end
    end

    // Checker: every popped byte is compared with the oldest owed byte.
    initial
    begin
        esc_byte_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                n_outputs++;
                if (escaped_q.size() == 0)
                begin
                    $display("%0t: unexpected output transfer, out_byte=%02h out_last=%0b",
                             $time, out_byte, out_last);
                    errors++;
                end
                else
                begin
                    e = escaped_q.pop_front();
                    if (out_byte !== e.data)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                                 $time, e.data, out_byte);
                        errors++;
                    end
                    if (out_last !== e.last)
                    begin
                        $display("%0t: out_last mismatch, expected %0b, actual %0b",
                                 $time, e.last, out_last);
                        errors++;
                    end
                end
            end
        end
    end

    // Extremes of the byte range, every escape letter, the zero byte, delete,
    // high bytes and the neighbors of the special characters.
    task automatic test_directed();
        logic [7:0] picks[$];
        picks = '{8'h00, 8'h1F, 8'h01, 8'h10, 8'h1A, 8'h1E,
                  8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B, 8'h07, 8'h0E,
                  8'h22, 8'h5C, 8'h21, 8'h23, 8'h5B, 8'h5D,
                  8'h20, 8'h7F, 8'h80, 8'hFF, 8'h41};
        pop_always = 1'b1;
        foreach (picks[i])
        begin
            send_byte(picks[i]);
        end
        hold_input(1);
        wait_drained();
    endtask

    // Full rate on both sides: escapes must backpressure the input cleanly.
    task automatic test_back_to_back();
        pop_always = 1'b1;
        send_random(100, 1'b0);
        hold_input(1);
        wait_drained();
    endtask

    // Random gaps on the input and random stalls on the output, in segments
    // of which one in four on average, picked at random, never stalls the output.
    task automatic test_random_stalls();
        for (int seg = 0; seg < 10; seg++)
        begin
            pop_always = ($urandom_range(0, 3) == 0);
            send_random(25, 1'b1);
        end
        pop_always = 1'b0;
        hold_input(1);
        wait_drained();
    endtask

    // The sender stops after each burst until every owed byte has come out,
    // so the block restarts from idle many times.
    task automatic test_drain_pause();
        pop_always = 1'b0;
        for (int round = 0; round < 6; round++)
        begin
            send_random($urandom_range(5, 20), 1'b1);
            hold_input(1);
            wait_drained();
            hold_input($urandom_range(0, 5));
        end
    endtask

    initial
    begin
        errors     = 0;
        n_inputs   = 0;
        n_outputs  = 0;
        n_plain    = 0;
        n_short    = 0;
        n_unicode  = 0;
        pop_always = 1'b1;
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        in_byte    = 8'h00;

        repeat (4)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_random_stalls();
        test_drain_pause();

        // Everything is in; let the last bytes out and watch for strays.
        hold_input(1);
        wait_drained();
        repeat (SETTLE_CYCLES)
        begin
            @(posedge clk);
        end
        if (escaped_q.size() != 0)
        begin
            $display("%0t: %0d expected bytes never came out", $time, escaped_q.size());
            errors++;
        end

        $display("Encoded %0d source bytes into %0d output transfers over %0d cycles.",
                 n_inputs, n_outputs, cycles);
        $display("Mix: %0d passed through, %0d short escapes, %0d \\u00XX escapes.",
                 n_plain, n_short, n_unicode);
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
